FILE: design/value_to_color_ramp_defines.svh
// assertion macros of the color ramp design, used by its top level
`ifndef VALUE_TO_COLOR_RAMP_DEFINES_SVH
`define VALUE_TO_COLOR_RAMP_DEFINES_SVH

// clocked check, masked while reset is asserted
`define VCR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check on the standard clock and reset names
`define VCR_ASSERT_STD(label, prop, msg) \
  `VCR_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

FILE: design/vcr_pkg.sv
// types, constants and ramp table of the value to color ramp
package vcr_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 8;
  localparam int RAMP_ENTRIES  = 31;
  localparam int RAMP_LAST     = RAMP_ENTRIES - 1;
  localparam int RAMP_MID      = RAMP_LAST / 2;
  localparam int COLOR_SCALE   = 204;
  localparam int ENT_W         = 5;
  localparam int ENT_FRAC      = 4;
  localparam int COLOR_W       = 8;
  localparam int QUO_W         = $clog2(RAMP_LAST << FRACTION_BITS);
  localparam int IDX_W         = QUO_W - FRACTION_BITS;
  localparam int DIVD_W        = SAMPLE_BITS + QUO_W;
  localparam int T_W           = ENT_W + FRACTION_BITS + 2;
  localparam int SCALE_W       = 8;
  localparam int CFG_IDX_W     = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_BOUND  = 1'b0,
    REG_HIGH_BOUND = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_INTERP,
    KIND_ZERO_SPAN,
    KIND_BELOW,
    KIND_ABOVE
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic [SAMPLE_BITS-1:0] d;
    logic [SAMPLE_BITS-1:0] span;
  } front_t;

  typedef struct packed {
    kind_e                  kind;
    logic [SAMPLE_BITS-1:0] rem;
    logic [SAMPLE_BITS-1:0] span;
    logic [QUO_W-1:0]       low;
    logic [QUO_W-1:0]       quo;
  } div_t;

  // red in [2], green in [1], blue in [0]
  typedef logic [2:0][ENT_W-1:0] ent_t;
  typedef logic [2:0][FRACTION_BITS+ENT_W-1:0] mix_t;
  typedef logic [2:0][COLOR_W-1:0] rgb_t;

  // ramp entries in sixteenths of full intensity
  function automatic ent_t ramp_entry(input logic [IDX_W-1:0] idx);
    ent_t e;
    case (idx)
      0:       e = {5'd0,  5'd0,  5'd16};
      1:       e = {5'd0,  5'd1,  5'd15};
      2:       e = {5'd0,  5'd2,  5'd14};
      3:       e = {5'd0,  5'd3,  5'd13};
      4:       e = {5'd0,  5'd4,  5'd12};
      5:       e = {5'd0,  5'd5,  5'd11};
      6:       e = {5'd0,  5'd6,  5'd10};
      7:       e = {5'd0,  5'd7,  5'd9};
      8:       e = {5'd0,  5'd9,  5'd7};
      9:       e = {5'd0,  5'd10, 5'd6};
      10:      e = {5'd0,  5'd11, 5'd5};
      11:      e = {5'd0,  5'd12, 5'd4};
      12:      e = {5'd0,  5'd13, 5'd3};
      13:      e = {5'd0,  5'd14, 5'd2};
      14:      e = {5'd0,  5'd15, 5'd1};
      15:      e = {5'd0,  5'd16, 5'd0};
      16:      e = {5'd1,  5'd15, 5'd0};
      17:      e = {5'd2,  5'd14, 5'd0};
      18:      e = {5'd3,  5'd13, 5'd0};
      19:      e = {5'd4,  5'd12, 5'd0};
      20:      e = {5'd5,  5'd11, 5'd0};
      21:      e = {5'd6,  5'd10, 5'd0};
      22:      e = {5'd7,  5'd9,  5'd0};
      23:      e = {5'd9,  5'd7,  5'd0};
      24:      e = {5'd10, 5'd6,  5'd0};
      25:      e = {5'd11, 5'd5,  5'd0};
      26:      e = {5'd12, 5'd4,  5'd0};
      27:      e = {5'd13, 5'd3,  5'd0};
      28:      e = {5'd14, 5'd2,  5'd0};
      29:      e = {5'd15, 5'd1,  5'd0};
      30:      e = {5'd16, 5'd0,  5'd0};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

FILE: design/vcr_if.sv
// request channels of the value to color ramp
interface vcr_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [vcr_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface vcr_color_if;
  logic                            valid;
  logic                            ready;
  logic [vcr_pkg::COLOR_W-1:0]     red;
  logic [vcr_pkg::COLOR_W-1:0]     green;
  logic [vcr_pkg::COLOR_W-1:0]     blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

FILE: design/vcr_front.sv
// bound registers, range classification and dividend build
module vcr_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vcr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [vcr_pkg::SAMPLE_BITS-1:0]     cfg_data_i,
  vcr_sample_if.sink                          sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output vcr_pkg::div_t                       out_data_o
);

  localparam int SB = vcr_pkg::SAMPLE_BITS;

  logic signed [SB-1:0] low_bound_q, high_bound_q;
  logic                 s1_v_q, s2_v_q;
  logic                 s1_ready, s2_ready;
  vcr_pkg::front_t      s1_d, s1_q;
  vcr_pkg::div_t        s2_d, s2_q;
  logic signed [SB:0]   diff_v, diff_span;
  logic [SB+4:0]        times30;
  logic [vcr_pkg::DIVD_W-1:0] divd;

  // bound registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_bound_q  <= '0;
      high_bound_q <= {1'b0, {(SB-1){1'b1}}};
    end else if (cfg_we_i) begin
      unique case (vcr_pkg::reg_idx_e'(cfg_idx_i))
        vcr_pkg::REG_LOW_BOUND:  low_bound_q  <= cfg_data_i;
        vcr_pkg::REG_HIGH_BOUND: high_bound_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s1_ready       = !s1_v_q || s2_ready;
  assign s2_ready       = !s2_v_q || out_ready_i;
  assign sample_i.ready = s1_ready;

  // stage 1: classify against the bounds
  always_comb begin
    diff_v    = {sample_i.sample[SB-1], sample_i.sample} - {low_bound_q[SB-1], low_bound_q};
    diff_span = {high_bound_q[SB-1], high_bound_q} - {low_bound_q[SB-1], low_bound_q};
    s1_d.d    = diff_v[SB-1:0];
    s1_d.span = diff_span[SB-1:0];
    if (high_bound_q == low_bound_q) begin
      s1_d.kind = vcr_pkg::KIND_ZERO_SPAN;
    end else if (sample_i.sample <= low_bound_q) begin
      s1_d.kind = vcr_pkg::KIND_BELOW;
    end else if (sample_i.sample >= high_bound_q) begin
      s1_d.kind = vcr_pkg::KIND_ABOVE;
    end else begin
      s1_d.kind = vcr_pkg::KIND_INTERP;
    end
  end

  // stage 2: dividend d*30 scaled by the fraction bits
  always_comb begin
    times30   = {s1_q.d, 5'b0} - {4'b0, s1_q.d, 1'b0};
    divd      = {times30, {vcr_pkg::FRACTION_BITS{1'b0}}};
    s2_d.kind = s1_q.kind;
    s2_d.span = s1_q.span;
    s2_d.rem  = divd[vcr_pkg::DIVD_W-1:vcr_pkg::QUO_W];
    s2_d.low  = divd[vcr_pkg::QUO_W-1:0];
    s2_d.quo  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= sample_i.valid;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && s1_ready) begin
      s1_q <= s1_d;
    end
    if (s1_v_q && s2_ready) begin
      s2_q <= s2_d;
    end
  end

  assign out_valid_o = s2_v_q;
  assign out_data_o  = s2_q;

endmodule

FILE: design/vcr_div_step.sv
// one restoring division step, one quotient bit per stage
module vcr_div_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  vcr_pkg::div_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output vcr_pkg::div_t out_data_o
);

  localparam int SB = vcr_pkg::SAMPLE_BITS;
  localparam int QW = vcr_pkg::QUO_W;

  logic          v_q;
  vcr_pkg::div_t step_d, step_q;
  logic [SB:0]   trial;
  logic [SB:0]   less;
  logic          take;

  always_comb begin
    trial       = {in_data_i.rem, in_data_i.low[QW-1]};
    less        = trial - {1'b0, in_data_i.span};
    take        = trial >= {1'b0, in_data_i.span};
    step_d      = in_data_i;
    step_d.rem  = take ? less[SB-1:0] : trial[SB-1:0];
    step_d.low  = {in_data_i.low[QW-2:0], 1'b0};
    step_d.quo  = {in_data_i.quo[QW-2:0], take};
  end

  assign in_ready_o = !v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      step_q <= step_d;
    end
  end

  assign out_valid_o = v_q;
  assign out_data_o  = step_q;

endmodule

FILE: design/vcr_interp.sv
// entry lookup, linear blend and 0.8 output scaling
module vcr_interp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  vcr_pkg::div_t        in_data_i,
  vcr_color_if.source          color_o
);

  localparam int F  = vcr_pkg::FRACTION_BITS;
  localparam int TW = vcr_pkg::T_W;
  localparam int MW = F + vcr_pkg::ENT_W;
  localparam int PW = MW + vcr_pkg::SCALE_W;

  logic                        a_v_q, b_v_q;
  logic                        a_ready, b_ready;
  logic [vcr_pkg::IDX_W-1:0]   idx;
  logic [F-1:0]                frac;
  vcr_pkg::ent_t               e0, e1;
  vcr_pkg::mix_t               mix_d, mix_q;
  vcr_pkg::rgb_t               rgb_d, rgb_q;
  logic signed [TW-1:0]        base, prod, sum;
  logic signed [vcr_pkg::ENT_W:0] step;
  logic [PW-1:0]               scaled;

  // stage a: pick neighbors and blend
  always_comb begin
    case (in_data_i.kind)
      vcr_pkg::KIND_INTERP: begin
        idx  = in_data_i.quo[vcr_pkg::QUO_W-1:F];
        frac = in_data_i.quo[F-1:0];
      end
      vcr_pkg::KIND_ZERO_SPAN: begin
        idx  = vcr_pkg::IDX_W'(vcr_pkg::RAMP_MID);
        frac = '0;
      end
      vcr_pkg::KIND_ABOVE: begin
        idx  = vcr_pkg::IDX_W'(vcr_pkg::RAMP_LAST);
        frac = '0;
      end
      default: begin
        idx  = '0;
        frac = '0;
      end
    endcase
    e0    = vcr_pkg::ramp_entry(idx);
    e1    = vcr_pkg::ramp_entry(idx + vcr_pkg::IDX_W'(1));
    base  = '0;
    prod  = '0;
    sum   = '0;
    step  = '0;
    mix_d = '0;
    for (int ch = 0; ch < 3; ch++) begin
      step      = $signed({1'b0, e1[ch]}) - $signed({1'b0, e0[ch]});
      base      = $signed({2'b00, e0[ch], {F{1'b0}}});
      prod      = TW'($signed({1'b0, frac})) * TW'(step);
      sum       = base + prod;
      mix_d[ch] = sum[MW-1:0];
    end
  end

  // stage b: scale by 204/16 and truncate
  always_comb begin
    scaled = '0;
    rgb_d  = '0;
    for (int ch = 0; ch < 3; ch++) begin
      scaled    = PW'(mix_q[ch]) * PW'(vcr_pkg::COLOR_SCALE);
      rgb_d[ch] = scaled[F+vcr_pkg::ENT_FRAC +: vcr_pkg::COLOR_W];
    end
  end

  assign b_ready    = !b_v_q || color_o.ready;
  assign a_ready    = !a_v_q || b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_v_q <= in_valid_i;
      end
      if (b_ready) begin
        b_v_q <= a_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_ready) begin
      mix_q <= mix_d;
    end
    if (a_v_q && b_ready) begin
      rgb_q <= rgb_d;
    end
  end

  assign color_o.valid = b_v_q;
  assign color_o.red   = rgb_q[2];
  assign color_o.green = rgb_q[1];
  assign color_o.blue  = rgb_q[0];

endmodule

FILE: design/value_to_color_ramp.sv
// pipeline: 17 stages from an accepted request to its color on the output register
// throughput: one request per cycle while the output is not held, through the 13-stage quotient pipeline
// every stage has its own valid bit and takes a request whenever it is empty or moving
// reset: asynchronous active low, clears all valid bits, low bound 0, high bound 32767
// top level of the value to color ramp
`include "value_to_color_ramp_defines.svh"

module value_to_color_ramp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vcr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [vcr_pkg::SAMPLE_BITS-1:0] cfg_data_i,
  vcr_sample_if.sink                      sample_i,
  vcr_color_if.source                     color_o
);

  localparam int QW = vcr_pkg::QUO_W;

  logic          div_v [QW+1];
  logic          div_r [QW+1];
  vcr_pkg::div_t div_d [QW+1];

  vcr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (sample_i),
    .out_valid_o (div_v[0]),
    .out_ready_i (div_r[0]),
    .out_data_o  (div_d[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_div
    vcr_div_step u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (div_v[k]),
      .in_ready_o  (div_r[k]),
      .in_data_i   (div_d[k]),
      .out_valid_o (div_v[k+1]),
      .out_ready_i (div_r[k+1]),
      .out_data_o  (div_d[k+1])
    );
  end

  vcr_interp u_interp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (div_v[QW]),
    .in_ready_o (div_r[QW]),
    .in_data_i  (div_d[QW]),
    .color_o    (color_o)
  );

  // position never reaches the last ramp entry
  `VCR_ASSERT_STD(a_quo_range, div_v[QW] && div_d[QW].kind == vcr_pkg::KIND_INTERP |-> div_d[QW].quo < QW'(vcr_pkg::RAMP_LAST << vcr_pkg::FRACTION_BITS), "quotient out of ramp range")
  // the ramp never mixes red and blue
  `VCR_ASSERT_STD(a_no_magenta, color_o.valid |-> color_o.red == '0 || color_o.blue == '0, "red and blue both lit")
  // the input only stalls when every stage is full and the output is held
  `VCR_ASSERT_STD(a_stall_source, !sample_i.ready |-> color_o.valid && !color_o.ready, "input stalled without output backpressure")

endmodule
